>>> sv/mapfd_pkg.sv
// shared types and constants of the mean airtime per delivered frame block
// used by the channel interfaces, the controller, the datapath and the top level
package mapfd_pkg;

    localparam int ACTION_W   = 2;
    localparam int AIR_W      = 32;
    localparam int BOUND_W    = 31;
    localparam int TOTAL_W    = 48;
    localparam int COUNT_W    = 32;
    localparam int ESUM_W     = 48;
    localparam int MEAN_W     = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam int MEAN_FRAC_DEF = 8;

    localparam logic [BOUND_W-1:0] BOUND_RESET = BOUND_W'(1 << 24);

    // register index as decoded from paddr[2]
    localparam logic REG_BOUND = 1'b0;

    localparam logic [ACTION_W-1:0] ACT_FRAME   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

    typedef struct packed {
        logic frame;
        logic clear;
        logic div_start;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

>>> sv/mapfd_if.sv
// valid/ready channel interfaces for input events and result beats
// depends on mapfd_pkg for field widths
interface mapfd_in_if;
    logic                               valid;
    logic                               ready;
    logic [mapfd_pkg::ACTION_W-1:0]     action;
    logic                               has_tx_flags;
    logic signed [mapfd_pkg::AIR_W-1:0] airtime_us;
    logic                               tx_failed;

    modport source (output valid, output action, output has_tx_flags,
                    output airtime_us, output tx_failed, input ready);
    modport sink (input valid, input action, input has_tx_flags,
                  input airtime_us, input tx_failed, output ready);
endinterface

interface mapfd_out_if;
    logic                                valid;
    logic                                ready;
    logic                                mean_valid;
    logic [mapfd_pkg::MEAN_W-1:0]        mean_airtime;
    logic [mapfd_pkg::TOTAL_W-1:0]       total_airtime;
    logic [mapfd_pkg::COUNT_W-1:0]       ignored_count;
    logic signed [mapfd_pkg::ESUM_W-1:0] error_sum;

    modport source (output valid, output mean_valid, output mean_airtime,
                    output total_airtime, output ignored_count, output error_sum,
                    input ready);
    modport sink (input valid, input mean_valid, input mean_airtime,
                  input total_airtime, input ignored_count, input error_sum,
                  output ready);
endinterface

>>> sv/mean_airtime_per_delivered_frame.sv
// top level: mean airtime per delivered frame with apb bound register
// depends on mapfd_pkg, mapfd_if, mapfd_ctrl and mapfd_dp
//
// usage
//  - in_ch carries one event per beat: action 0 is a frame event, 1 asks for
//    the mean and totals, 2 clears all counters; code 3 is dropped
//  - a frame event with tx flags updates the saturating accumulators in
//    the cycle it is taken, so frame and clear beats stream at one per
//    cycle while no compute is in progress
//  - a compute beat gives one result beat on out_ch; the mean comes from a
//    restoring divider that retires one quotient bit per cycle, and the
//    result is loaded into the output register once the divide is done;
//    in_ch.ready stays low from the compute beat until that load
//  - the output register holds the result until out_ch.ready; frame beats
//    are still taken while it waits, a later compute waits in the load step
//  - the apb port holds airtime_upper_bound at byte address 0; pready is
//    always high and writes are meant for idle periods only
//  - reset clears all counters, drops any pending result beat and sets the
//    bound to 2^24 microseconds
module mean_airtime_per_delivered_frame #(
    parameter int MEAN_FRACTION_BITS = mapfd_pkg::MEAN_FRAC_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    mapfd_in_if.sink                            in_ch,
    mapfd_out_if.source                         out_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mapfd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mapfd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mapfd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    localparam int BW = mapfd_pkg::BOUND_W;

    // command and status between the controller and the datapath
    mapfd_pkg::cmd_t cmd;
    mapfd_pkg::sts_t sts;

    // plausibility bound register
    logic [BW-1:0] bound_reg;
    logic [BW-1:0] bound_next;
    logic          bound_hit;

    // register select ignores the byte lane bits
    assign bound_hit = (paddr[2] == mapfd_pkg::REG_BOUND);

    always_comb
    begin
        bound_next = bound_reg;
        if (psel && penable && pwrite && pready && bound_hit)
        begin
            bound_next = pwdata[BW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg <= mapfd_pkg::BOUND_RESET;
        end
        else
        begin
            bound_reg <= bound_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = bound_hit ? {{(mapfd_pkg::APB_DATA_W-BW){1'b0}}, bound_reg} : '0;

    // event decode and divide sequencing
    mapfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .action   (in_ch.action),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // accumulators, divider and result register
    mapfd_dp #(
        .MEAN_FRACTION_BITS (MEAN_FRACTION_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .has_tx_flags  (in_ch.has_tx_flags),
        .airtime_us    (in_ch.airtime_us),
        .tx_failed     (in_ch.tx_failed),
        .bound         (bound_reg),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .mean_valid    (out_ch.mean_valid),
        .mean_airtime  (out_ch.mean_airtime),
        .total_airtime (out_ch.total_airtime),
        .ignored_count (out_ch.ignored_count),
        .error_sum     (out_ch.error_sum)
    );

endmodule

>>> sv/mapfd_ctrl.sv
// controller: decodes events, sequences the divider and the result load
// depends on mapfd_pkg for action codes and the command/status structs
module mapfd_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [mapfd_pkg::ACTION_W-1:0] action,
    output logic                           in_ready,
    input  mapfd_pkg::sts_t                sts,
    output mapfd_pkg::cmd_t                cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (action)
                        mapfd_pkg::ACT_FRAME:   cmd.frame = 1'b1;
                        mapfd_pkg::ACT_CLEAR:   cmd.clear = 1'b1;
                        mapfd_pkg::ACT_COMPUTE:
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = ST_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !in_ready)
        else $error("input taken while divider busy");

    a_div_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && sts.div_last) |=> state_reg == ST_LOAD)
        else $error("last divide step did not move to load");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over a pending beat");

    a_start_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> state_reg == ST_DIV)
        else $error("divider start did not enter divide state");
`endif

endmodule

>>> sv/mapfd_dp.sv
// datapath: saturating accumulators, radix-2 restoring divider, result register
// depends on mapfd_pkg for widths and the command/status structs
module mapfd_dp #(
    parameter int MEAN_FRACTION_BITS = mapfd_pkg::MEAN_FRAC_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mapfd_pkg::cmd_t                     cmd,
    output mapfd_pkg::sts_t                     sts,
    input  logic                                has_tx_flags,
    input  logic signed [mapfd_pkg::AIR_W-1:0]  airtime_us,
    input  logic                                tx_failed,
    input  logic [mapfd_pkg::BOUND_W-1:0]       bound,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic                                mean_valid,
    output logic [mapfd_pkg::MEAN_W-1:0]        mean_airtime,
    output logic [mapfd_pkg::TOTAL_W-1:0]       total_airtime,
    output logic [mapfd_pkg::COUNT_W-1:0]       ignored_count,
    output logic signed [mapfd_pkg::ESUM_W-1:0] error_sum
);

    localparam int TW    = mapfd_pkg::TOTAL_W;
    localparam int CW    = mapfd_pkg::COUNT_W;
    localparam int EW    = mapfd_pkg::ESUM_W;
    localparam int AW    = mapfd_pkg::AIR_W;
    localparam int MW    = mapfd_pkg::MEAN_W;
    localparam int DW    = TW + MEAN_FRACTION_BITS;
    localparam int CNT_W = $clog2(DW);

    logic [TW-1:0] total_reg, total_next;
    logic [CW-1:0] deliv_reg, deliv_next;
    logic [CW-1:0] rej_reg, rej_next;
    logic [EW-1:0] esum_reg, esum_next;

    logic [DW-1:0]    dq_reg, dq_next;
    logic [CW-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic          out_valid_reg;
    logic          mean_valid_reg;
    logic [MW-1:0] mean_reg;
    logic [TW-1:0] tot_out_reg;
    logic [CW-1:0] ign_out_reg;
    logic [EW-1:0] esum_out_reg;

    logic          plausible;
    logic [TW:0]   tot_sum;
    logic [EW:0]   err_sum;
    logic [CW:0]   shifted;
    logic [CW+1:0] diff;
    logic          qbit;
    logic [MW-1:0] mean_sat;

    // airtime in (0, bound)
    assign plausible = !airtime_us[AW-1] && (|airtime_us[AW-2:0])
                       && (airtime_us[AW-2:0] < bound);
    assign tot_sum   = {1'b0, total_reg} + {{(TW-AW+1){1'b0}}, airtime_us};
    assign err_sum   = {esum_reg[EW-1], esum_reg} + {{(EW-AW+1){airtime_us[AW-1]}}, airtime_us};

    always_comb
    begin
        total_next = total_reg;
        deliv_next = deliv_reg;
        rej_next   = rej_reg;
        esum_next  = esum_reg;
        if (cmd.clear)
        begin
            total_next = '0;
            deliv_next = '0;
            rej_next   = '0;
            esum_next  = '0;
        end
        else if (cmd.frame && has_tx_flags)
        begin
            if (plausible)
            begin
                total_next = tot_sum[TW] ? {TW{1'b1}} : tot_sum[TW-1:0];
                if (!tx_failed && deliv_reg != {CW{1'b1}})
                begin
                    deliv_next = deliv_reg + 1'b1;
                end
            end
            else
            begin
                if (rej_reg != {CW{1'b1}})
                begin
                    rej_next = rej_reg + 1'b1;
                end
                // clamp on signed overflow
                if (err_sum[EW] != err_sum[EW-1])
                begin
                    esum_next = err_sum[EW] ? {1'b1, {(EW-1){1'b0}}}
                                            : {1'b0, {(EW-1){1'b1}}};
                end
                else
                begin
                    esum_next = err_sum[EW-1:0];
                end
            end
        end
    end

    // one quotient bit per step, dividend bits shift out as quotient bits shift in
    assign shifted = {rem_reg, dq_reg[DW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, deliv_reg};
    assign qbit    = !diff[CW+1];

    always_comb
    begin
        dq_next  = dq_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (cmd.div_start)
        begin
            dq_next  = DW'(total_reg) << MEAN_FRACTION_BITS;
            rem_next = '0;
            cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            dq_next  = {dq_reg[DW-2:0], qbit};
            rem_next = qbit ? diff[CW-1:0] : shifted[CW-1:0];
            cnt_next = cnt_reg + 1'b1;
        end
    end

    assign mean_sat = (|dq_reg[DW-1:MW]) ? {MW{1'b1}} : dq_reg[MW-1:0];

    assign sts.div_last = (cnt_reg == CNT_W'(DW - 1));
    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            deliv_reg     <= '0;
            rej_reg       <= '0;
            esum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            deliv_reg <= deliv_next;
            rej_reg   <= rej_next;
            esum_reg  <= esum_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (cmd.load_out)
        begin
            mean_valid_reg <= (deliv_reg != '0);
            mean_reg       <= (deliv_reg != '0) ? mean_sat : '0;
            tot_out_reg    <= total_reg;
            ign_out_reg    <= rej_reg;
            esum_out_reg   <= esum_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mean_valid    = mean_valid_reg;
    assign mean_airtime  = mean_reg;
    assign total_airtime = tot_out_reg;
    assign ignored_count = ign_out_reg;
    assign error_sum     = esum_out_reg;

endmodule
